[hdl/sorted_priority_queue_unit_assert.svh]
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_assert.svh
// Assertion macros used by the priority queue top module.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Clocked check on i_clk, masked while i_rst_n is low.
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check on i_clk that also holds during reset.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int OCC_W    = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [PRIO_W-1:0]         t_prio;
    typedef logic [CNT_W-1:0]          t_count;
    typedef logic [OCC_W-1:0]          t_occ;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic  enq;
        logic  deq;
        t_prio new_prio;
    } t_cell_cmd;

endpackage

[hdl/sorted_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Priority queue kept sorted in a chain of cells; ties leave first in,
// first out. Enqueue inserts, dequeue returns the head entry.
// ----------------------------------------------------------------------------
//  channel  | valid       | ready        | payload
//  request  | i_in_valid  | o_in_ready   | i_opcode, i_item_value, i_item_priority
//  result   | o_out_valid | i_out_ready  | o_status, o_out_value, o_out_priority,
//           |             |              | o_occupancy
//
//  One request per cycle: all cells compare against the new priority and
//  shift in the same cycle; the result is registered and is valid in the next cycle.
//  o_in_ready drops only while a result is held and i_out_ready is low.
//  Reset clears the entry count and the output valid; cell contents are
//  not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_opcode,
    input  spq_pkg::t_value     i_item_value,
    input  spq_pkg::t_prio      i_item_priority,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output spq_pkg::t_value     o_out_value,
    output spq_pkg::t_prio      o_out_priority,
    output spq_pkg::t_occ       o_occupancy
);
    import spq_pkg::*;

    `include "sorted_priority_queue_unit_assert.svh"

    t_count    r_count;
    t_count    n_count;
    logic      r_out_valid;
    t_status   r_status;
    t_status   n_status;
    t_value    r_out_value;
    t_value    n_out_value;
    t_prio     r_out_prio;
    t_prio     n_out_prio;
    t_occ      r_occ;
    t_occ      n_occ;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_cmd w_cmd;
    logic [CNT_W+OCC_W-1:0] w_count_ext;

    logic   [CAPACITY-1:0] w_occ;
    logic   [CAPACITY-1:0] w_stay;
    t_value [CAPACITY-1:0] w_value;
    t_prio  [CAPACITY-1:0] w_prio;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == t_count'(CAPACITY));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_cmd.enq      = w_accept && (i_opcode == OP_ENQ) && !w_full;
        w_cmd.deq      = w_accept && (i_opcode == OP_DEQ) && !w_empty;
        w_cmd.new_prio = i_item_priority;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_value c_prev_value;
            t_prio  c_prev_prio;
            logic   c_prev_stay;
            t_value c_next_value;
            t_prio  c_next_prio;

            assign w_occ[gi] = (r_count > t_count'(gi));

            if (gi == 0) begin : g_head
                assign c_prev_stay  = 1'b1;
                assign c_prev_value = i_item_value;
                assign c_prev_prio  = i_item_priority;
            end else begin : g_body
                assign c_prev_stay  = w_stay[gi-1];
                assign c_prev_value = w_value[gi-1];
                assign c_prev_prio  = w_prio[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                // last slot is vacated by a remove; its content is don't-care
                assign c_next_value = w_value[gi];
                assign c_next_prio  = w_prio[gi];
            end else begin : g_link
                assign c_next_value = w_value[gi+1];
                assign c_next_prio  = w_prio[gi+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_occ        (w_occ[gi]),
                .i_prev_stay  (c_prev_stay),
                .i_new_value  (i_item_value),
                .i_prev_value (c_prev_value),
                .i_prev_prio  (c_prev_prio),
                .i_next_value (c_next_value),
                .i_next_prio  (c_next_prio),
                .o_stay       (w_stay[gi]),
                .o_value      (w_value[gi]),
                .o_prio       (w_prio[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_out_value = '0;
        n_out_prio  = '0;
        if (i_opcode == OP_ENQ) begin
            n_status = w_full ? ST_FULL : ST_INSERTED;
            if (!w_full) begin
                n_count = r_count + 1'b1;
            end
        end else begin
            n_status = w_empty ? ST_EMPTY : ST_DEQUEUED;
            if (!w_empty) begin
                n_count     = r_count - 1'b1;
                n_out_value = w_value[0];
                n_out_prio  = w_prio[0];
            end
        end
        w_count_ext = {{OCC_W{1'b0}}, n_count};
        n_occ       = w_count_ext[OCC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_out_value <= n_out_value;
            r_out_prio  <= n_out_prio;
            r_occ       <= n_occ;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = r_occ;

    `SPQ_ASSERT(a_count_bound, r_count <= t_count'(CAPACITY), "count over capacity")
    `SPQ_ASSERT(a_count_hold, !w_accept |=> $stable(r_count), "count moved without request")
    `SPQ_ASSERT(a_deq_result, w_cmd.deq |=> o_out_valid && o_status == ST_DEQUEUED, "dequeue lost")
    `SPQ_ASSERT(a_head_sorted, w_occ[1] |-> (w_prio[0] <= w_prio[1]), "head out of order")
    `SPQ_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid && r_count == '0, "reset not idle")

endmodule

[hdl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the new
// priority and shifts toward the tail on insert or toward the head on remove.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic              i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic              i_occ,
    input  logic              i_prev_stay,
    input  spq_pkg::t_value   i_new_value,
    input  spq_pkg::t_value   i_prev_value,
    input  spq_pkg::t_prio    i_prev_prio,
    input  spq_pkg::t_value   i_next_value,
    input  spq_pkg::t_prio    i_next_prio,
    output logic              o_stay,
    output spq_pkg::t_value   o_value,
    output spq_pkg::t_prio    o_prio
);
    import spq_pkg::*;

    t_value r_value;
    t_prio  r_prio;
    t_value n_value;
    t_prio  n_prio;

    // Entry stays put when it sorts before or ties with the new one
    assign o_stay = i_occ && (r_prio <= i_cmd.new_prio);

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_cmd.enq && !o_stay) begin
            if (i_prev_stay) begin
                n_value = i_new_value;
                n_prio  = i_cmd.new_prio;
            end else begin
                n_value = i_prev_value;
                n_prio  = i_prev_prio;
            end
        end else if (i_cmd.deq) begin
            n_value = i_next_value;
            n_prio  = i_next_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_value = r_value;
    assign o_prio  = r_prio;

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the sorted priority queue against a shadow queue kept in the bench.
// Directed corner requests come first. Random enqueue/dequeue mixes follow,
// with idle bursts on both channels, a long result stall that backs up the
// request side, and pauses until all results are back.
// ----------------------------------------------------------------------------
module tb;
    import spq_pkg::*;

    localparam int MAX_SHOWN = 10;
    localparam int LONG_HOLD = 48;
    localparam int TAIL_WAIT = 10;
    localparam int RUN_LIMIT = 2000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic       i_opcode;
    t_value     i_item_value;
    t_prio      i_item_priority;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [1:0] o_status;
    t_value     o_out_value;
    t_prio      o_out_priority;
    t_occ       o_occupancy;

    bit hold_results  = 1'b0;
    bit in_gaps_on    = 1'b1;
    bit out_stalls_on = 1'b1;

    typedef struct {
        t_value value;
        t_prio  prio;
    } t_queue_entry;

    typedef struct {
        t_status status;
        t_value  value;
        t_prio   prio;
        t_occ    occ;
    } t_queue_result;

    class queue_shadow;
        t_queue_entry  entries[$];
        t_queue_result expected_results[$];
        int            mismatches = 0;

        function void log_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("mismatch: %s", msg);
        endfunction

        function void note_request(t_opcode op, t_value value, t_prio prio);
            t_queue_result r;
            t_queue_entry  e;
            int            pos;
            r.value = '0;
            r.prio  = '0;
            if (op == OP_ENQ) begin
                if (entries.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // goes behind every entry with a lower or equal number
                    pos = 0;
                    while (pos < entries.size() && entries[pos].prio <= prio)
                        pos++;
                    e.value = value;
                    e.prio  = prio;
                    entries.insert(pos, e);
                    r.status = ST_INSERTED;
                end
            end else if (entries.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                e = entries.pop_front();
                r.value  = e.value;
                r.prio   = e.prio;
                r.status = ST_DEQUEUED;
            end
            r.occ = t_occ'(entries.size());
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, t_value value, t_prio prio, t_occ occ);
            t_queue_result r;
            if (expected_results.size() == 0) begin
                log_mismatch($sformatf("unexpected result st=%0d val=%h pri=%h occ=%0d",
                                       status, value, prio, occ));
            end else begin
                r = expected_results.pop_front();
                if (status !== r.status || value !== r.value ||
                    prio !== r.prio || occ !== r.occ)
                    log_mismatch($sformatf(
                        "exp st=%0d val=%h pri=%h occ=%0d, got st=%0d val=%h pri=%h occ=%0d",
                        r.status, r.value, r.prio, r.occ, status, value, prio, occ));
            end
        endfunction
    endclass

    queue_shadow shadow;

    sorted_priority_queue_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_occupancy     (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // results are checked before the same edge's request is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                shadow.check_result(o_status, o_out_value, o_out_priority, o_occupancy);
            if (i_in_valid && o_in_ready)
                shadow.note_request(t_opcode'(i_opcode), i_item_value, i_item_priority);
        end
    end

    // result side: random stall bursts, plus one long hold on request
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (out_stalls_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    function automatic t_value random_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // narrow range a third of the time so equal priorities are common
    function automatic t_prio random_priority();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return t_prio'($urandom_range(0, 3));
            default: return t_prio'($urandom_range(0, 65535));
        endcase
    endfunction

    // returns at the edge where the request is taken
    task automatic send_request(t_opcode op, t_value value, t_prio prio);
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_item_value    <= value;
        i_item_priority <= prio;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.expected_results.size() != 0);
    endtask

    task automatic run_random(int count, int enq_pct);
        t_opcode op;
        repeat (count) begin
            op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
            send_request(op, random_value(), random_priority());
            if (in_gaps_on && $urandom_range(0, 3) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        shadow = new();
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_opcode        <= OP_ENQ;
        i_item_value    <= '0;
        i_item_priority <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // dequeue from empty, extremes, ties on both ends, then empty again
        send_request(OP_DEQ, random_value(), random_priority());
        send_request(OP_ENQ, 32'h7FFF_FFFF, 16'hFFFF);
        send_request(OP_ENQ, 32'h8000_0000, 16'h0000);
        send_request(OP_ENQ, 32'h0000_0000, 16'h0000);
        send_request(OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_ENQ, 32'h5555_AAAA, 16'h8000);
        send_request(OP_ENQ, 32'h1234_5678, 16'h0001);
        repeat (7) send_request(OP_DEQ, random_value(), random_priority());
        drain_results();

        run_random(120, 50);

        // long result stall: the request side backs up and the queue overflows
        hold_results = 1'b1;
        repeat (30) send_request(OP_ENQ, random_value(), random_priority());
        drain_results();

        run_random(100, 80);
        run_random(100, 25);
        drain_results();

        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        run_random(80, 50);
        drain_results();
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (shadow.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule
